>>> hdl/sha1_pkg.sv
// Shared types and constants for the SHA-1 hash engine.
// Used by every module of the engine; depends on nothing.
`timescale 1ns / 1ps

package sha1_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [4:0] chain_t;

  localparam int DIGEST_WORDS = 5;
  localparam int BLOCK_WORDS  = 16;
  localparam int ROUNDS       = 80;
  localparam int CMD_DEPTH    = 4;

  localparam logic [2:0] LAST_INDEX = 3'(DIGEST_WORDS - 1);

  // Initial chaining value, H0 in entry 0.
  localparam chain_t SHA1_IV = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam word_t K_R0 = 32'h5A827999;
  localparam word_t K_R1 = 32'h6ED9EBA1;
  localparam word_t K_R2 = 32'h8F1BBCDC;
  localparam word_t K_R3 = 32'hCA62C1D6;

  localparam word_t PAD_MARKER = 32'h80000000;

  // One classified request from the front end to the compression engine.
  typedef struct packed {
    logic       is_last;      // final word of the message
    logic       marker_next;  // pad marker needs a word of its own
    logic [5:0] add_bits;     // bits this word adds to the length
    word_t      word;         // masked word, pad marker already merged if it fits
  } cmd_t;

endpackage

>>> hdl/sha1_front.sv
// Front end: accepts message words and classifies them into engine requests.
// Depends on sha1_pkg.
`timescale 1ns / 1ps

module sha1_front (
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [31:0]      s_axis_tdata,   // data_word
  input  logic [2:0]       s_axis_tuser,   // byte_count
  input  logic             s_axis_tlast,   // last_word
  output logic             cmd_valid,
  input  logic             cmd_ready,
  output sha1_pkg::cmd_t   cmd
);
  import sha1_pkg::*;

  logic [2:0] count;
  word_t      mask;
  word_t      pad;

  // Counts above four are taken as four.
  assign count = (s_axis_tuser > 3'd4) ? 3'd4 : s_axis_tuser;

  always_comb begin
    case (count)
      3'd0: begin
        mask = 32'h00000000;
        pad  = 32'h80000000;
      end
      3'd1: begin
        mask = 32'hFF000000;
        pad  = 32'h00800000;
      end
      3'd2: begin
        mask = 32'hFFFF0000;
        pad  = 32'h00008000;
      end
      3'd3: begin
        mask = 32'hFFFFFF00;
        pad  = 32'h00000080;
      end
      default: begin
        mask = 32'hFFFFFFFF;
        pad  = 32'h00000000;
      end
    endcase
  end

  always_comb begin
    cmd.is_last = s_axis_tlast;
    if (s_axis_tlast) begin
      cmd.marker_next = (count == 3'd4);
      cmd.add_bits    = {count, 3'b000};
      cmd.word        = (s_axis_tdata & mask) | pad;
    end else begin
      // A short count on a word that is not last is ignored.
      cmd.marker_next = 1'b0;
      cmd.add_bits    = 6'd32;
      cmd.word        = s_axis_tdata;
    end
  end

  assign cmd_valid     = s_axis_tvalid;
  assign s_axis_tready = cmd_ready;

endmodule

>>> hdl/sha1_cmd_fifo.sv
// Short request queue between the front end and the compression engine.
// Depends on sha1_pkg.
`timescale 1ns / 1ps

module sha1_cmd_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  sha1_pkg::cmd_t  wr_data,
  output logic            rd_valid,
  input  logic            rd_ready,
  output sha1_pkg::cmd_t  rd_data
);
  import sha1_pkg::*;

  localparam int PW = $clog2(CMD_DEPTH);
  localparam int CW = $clog2(CMD_DEPTH + 1);

  cmd_t          slots [CMD_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] fill;
  logic          do_wr;
  logic          do_rd;

  assign wr_ready = (fill != CW'(CMD_DEPTH));
  assign rd_valid = (fill != '0);
  assign rd_data  = slots[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(CMD_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(CMD_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

>>> hdl/sha1_core.sv
// Compression engine: block buffer, message schedule, padding and 80 rounds.
// Depends on sha1_pkg.
`timescale 1ns / 1ps

module sha1_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  sha1_pkg::cmd_t   cmd,
  output logic             dig_valid,
  input  logic             dig_ready,
  output sha1_pkg::chain_t dig_data
);
  import sha1_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MARK, S_ZERO, S_LENLO, S_ROUND, S_ADD, S_DIGEST
  } state_t;

  state_t      state;
  state_t      ret;
  state_t      target;
  word_t       sr [BLOCK_WORDS];
  logic [3:0]  fill;
  logic [63:0] bits;
  chain_t      h;
  word_t       a, b, c, d, e;
  logic [6:0]  t;

  logic        push;
  word_t       push_word;
  word_t       f;
  word_t       k;
  word_t       tmp;
  word_t       w_new;

  // Which word goes into the block buffer this cycle, and where to go next.
  always_comb begin
    push      = 1'b0;
    push_word = '0;
    target    = state;
    cmd_ready = 1'b0;
    case (state)
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          push      = 1'b1;
          push_word = cmd.word;
          if (!cmd.is_last) begin
            target = S_IDLE;
          end else if (cmd.marker_next) begin
            target = S_MARK;
          end else begin
            target = S_ZERO;
          end
        end
      end
      S_MARK: begin
        push      = 1'b1;
        push_word = PAD_MARKER;
        target    = S_ZERO;
      end
      S_ZERO: begin
        push = 1'b1;
        if (fill == 4'd14) begin
          push_word = bits[63:32];
          target    = S_LENLO;
        end else begin
          push_word = '0;
          target    = S_ZERO;
        end
      end
      S_LENLO: begin
        push      = 1'b1;
        push_word = bits[31:0];
        target    = S_DIGEST;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (t < 7'd20) begin
      f = (b & c) | (~b & d);
      k = K_R0;
    end else if (t < 7'd40) begin
      f = b ^ c ^ d;
      k = K_R1;
    end else if (t < 7'd60) begin
      f = (b & c) | (b & d) | (c & d);
      k = K_R2;
    end else begin
      f = b ^ c ^ d;
      k = K_R3;
    end
  end

  // sr[0] holds w[t]; the schedule word w[t+16] enters at the top.
  assign tmp   = {a[26:0], a[31:27]} + f + e + sr[0] + k;
  assign w_new = {sr[13][30:0] ^ sr[8][30:0] ^ sr[2][30:0] ^ sr[0][30:0],
                  sr[13][31] ^ sr[8][31] ^ sr[2][31] ^ sr[0][31]};

  assign dig_valid = (state == S_DIGEST);
  assign dig_data  = h;

  always_ff @(posedge clk) begin
    if (push || state == S_ROUND) begin
      for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
        sr[i] <= sr[i + 1];
      end
      sr[BLOCK_WORDS - 1] <= push ? push_word : w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_IDLE;
      fill  <= '0;
      bits  <= '0;
      h     <= SHA1_IV;
      t     <= '0;
    end else begin
      if (state == S_IDLE && cmd_valid) begin
        bits <= bits + 64'(cmd.add_bits);
      end
      if (push) begin
        fill <= fill + 1'b1;
        if (fill == 4'd15) begin
          // Block complete: start the rounds and resume afterwards.
          a     <= h[0];
          b     <= h[1];
          c     <= h[2];
          d     <= h[3];
          e     <= h[4];
          t     <= '0;
          ret   <= target;
          state <= S_ROUND;
        end else begin
          state <= target;
        end
      end else begin
        case (state)
          S_ROUND: begin
            a <= tmp;
            b <= a;
            c <= {b[1:0], b[31:2]};
            d <= c;
            e <= d;
            t <= t + 1'b1;
            if (t == 7'(ROUNDS - 1)) begin
              state <= S_ADD;
            end
          end
          S_ADD: begin
            h[0]  <= h[0] + a;
            h[1]  <= h[1] + b;
            h[2]  <= h[2] + c;
            h[3]  <= h[3] + d;
            h[4]  <= h[4] + e;
            state <= ret;
          end
          S_DIGEST: begin
            if (dig_ready) begin
              h     <= SHA1_IV;
              bits  <= '0;
              state <= S_IDLE;
            end
          end
          default: begin
            state <= state;
          end
        endcase
      end
    end
  end

endmodule

>>> hdl/sha1_digest_out.sv
// Digest output stage: holds a finished digest and sends it as five words.
// Depends on sha1_pkg.
`timescale 1ns / 1ps

module sha1_digest_out (
  input  logic             clk,
  input  logic             rst,
  input  logic             dig_valid,
  output logic             dig_ready,
  input  sha1_pkg::chain_t dig_data,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // digest_word
  output logic [2:0]       m_axis_tuser,  // digest_index
  output logic             m_axis_tlast   // digest_last
);
  import sha1_pkg::*;

  chain_t     dig_hold;
  logic       busy;
  logic [2:0] idx;

  assign dig_ready     = !busy;
  assign m_axis_tvalid = busy;
  assign m_axis_tdata  = dig_hold[idx];
  assign m_axis_tuser  = idx;
  assign m_axis_tlast  = (idx == LAST_INDEX);

  always_ff @(posedge clk) begin
    if (dig_valid && !busy) begin
      dig_hold <= dig_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (!busy) begin
      if (dig_valid) begin
        busy <= 1'b1;
        idx  <= '0;
      end
    end else if (m_axis_tready) begin
      if (idx == LAST_INDEX) begin
        busy <= 1'b0;
        idx  <= '0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

endmodule

>>> hdl/sha1_hash_engine.sv
// SHA-1 hash engine top level: front end, request queue, compression engine
// and digest output stage. Depends on sha1_pkg and the four submodules.
// A full 16-word block takes 16 requests, then 80 rounds and one add on the
// shared round unit; the engine takes no new request while these run.
// A last word adds padding and length words and one or two round passes, a
// handoff to the output stage, then five digest words, one per accepted
// output request. The request queue registers requests between input and engine.
// Synchronous reset clears the queue, the chaining value, length and fill.
`timescale 1ns / 1ps

module sha1_hash_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // data_word
  input  logic [2:0]  s_axis_tuser,   // byte_count
  input  logic        s_axis_tlast,   // last_word
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // digest_word
  output logic [2:0]  m_axis_tuser,   // digest_index
  output logic        m_axis_tlast    // digest_last
);
  import sha1_pkg::*;

  logic   fr_valid;
  logic   fr_ready;
  cmd_t   fr_cmd;
  logic   q_valid;
  logic   q_ready;
  cmd_t   q_cmd;
  logic   dig_valid;
  logic   dig_ready;
  chain_t dig_data;

  sha1_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .cmd_valid     (fr_valid),
    .cmd_ready     (fr_ready),
    .cmd           (fr_cmd)
  );

  sha1_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (fr_valid),
    .wr_ready (fr_ready),
    .wr_data  (fr_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_cmd)
  );

  sha1_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .dig_valid (dig_valid),
    .dig_ready (dig_ready),
    .dig_data  (dig_data)
  );

  sha1_digest_out u_out (
    .clk           (clk),
    .rst           (rst),
    .dig_valid     (dig_valid),
    .dig_ready     (dig_ready),
    .dig_data      (dig_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

>>> hdl/sha1_checker.sv
// Port-level checks for the SHA-1 hash engine, bound to its top level.
// Depends only on the top-level ports.
`timescale 1ns / 1ps

module sha1_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [31:0] s_axis_tdata,
  input logic [2:0]  s_axis_tuser,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // A stalled digest word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("digest word changed while stalled");

  // The last digest word is always index four.
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == 3'd4)))
    else $error("digest_last does not match digest_index");

  // Digest words follow one another without a gap, index counting up.
  a_index_step: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast
      |=> m_axis_tvalid && (m_axis_tuser == $past(m_axis_tuser) + 3'd1))
    else $error("digest index did not advance");

  // Nothing is offered on the output right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind sha1_hash_engine sha1_checker u_checker (.*);

>>> bench/tb_top.sv
// Self-checking bench for sha1_hash_engine: streams messages through the
// request port and checks every digest word against a built-in SHA-1 model.
// Depends on sha1_pkg and the sha1_hash_engine RTL.
`timescale 1ns / 1ps

module tb_top;
  import sha1_pkg::*;

  typedef struct packed {
    word_t      word;
    logic [2:0] index;
    logic       last;
  } digest_item_t;

  // Shadow SHA-1 engine plus the queue of digest words it predicts.
  class digest_scoreboard;
    word_t          blk [16];
    chain_t         chain;
    int unsigned    fill;
    logic [63:0]    msg_bits;
    digest_item_t   digest_q [$];
    int             errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      foreach (blk[i]) blk[i] = '0;
      chain    = SHA1_IV;
      fill     = 0;
      msg_bits = '0;
    endfunction

    function word_t rotate_left(word_t x, int n);
      return (x << n) | (x >> (32 - n));
    endfunction

    function void compress();
      word_t w [80];
      word_t a, b, c, d, e, f, k, t;
      for (int i = 0; i < 16; i++) w[i] = blk[i];
      for (int i = 16; i < 80; i++)
        w[i] = rotate_left(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
      a = chain[0];
      b = chain[1];
      c = chain[2];
      d = chain[3];
      e = chain[4];
      for (int i = 0; i < 80; i++) begin
        if (i < 20) begin
          f = (b & c) | (~b & d);
          k = K_R0;
        end else if (i < 40) begin
          f = b ^ c ^ d;
          k = K_R1;
        end else if (i < 60) begin
          f = (b & c) | (b & d) | (c & d);
          k = K_R2;
        end else begin
          f = b ^ c ^ d;
          k = K_R3;
        end
        t = rotate_left(a, 5) + f + e + w[i] + k;
        e = d;
        d = c;
        c = rotate_left(b, 30);
        b = a;
        a = t;
      end
      chain[0] += a;
      chain[1] += b;
      chain[2] += c;
      chain[3] += d;
      chain[4] += e;
    endfunction

    function void push_word(word_t w);
      blk[fill] = w;
      fill++;
      if (fill >= 16) begin
        compress();
        fill = 0;
      end
    endfunction

    // Called for every accepted input request.
    function void note_request(word_t data, logic [2:0] count, logic last);
      int unsigned  nbytes;
      word_t        mask;
      word_t        w;
      digest_item_t item;
      if (!last) begin
        // A short count on a word that is not last is ignored.
        msg_bits += 64'd32;
        push_word(data);
        return;
      end
      nbytes = (count > 3'd4) ? 4 : count;
      msg_bits += 64'(nbytes * 8);
      mask = (nbytes == 0) ? '0 : (32'hFFFF_FFFF << (32 - 8 * nbytes));
      w = data & mask;
      if (nbytes < 4) begin
        w |= 32'h80 << (8 * (3 - nbytes));
        push_word(w);
      end else begin
        push_word(w);
        push_word(PAD_MARKER);
      end
      while (fill != 14) push_word('0);
      push_word(msg_bits[63:32]);
      push_word(msg_bits[31:0]);
      for (int i = 0; i < DIGEST_WORDS; i++) begin
        item.word  = chain[i];
        item.index = 3'(i);
        item.last  = (i == DIGEST_WORDS - 1);
        digest_q.push_back(item);
      end
      clear();
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("[%0t] digest mismatch: %s got %h want %h", $realtime, what, got, want);
    endtask

    task check_digest(word_t word, logic [2:0] index, logic last);
      digest_item_t want;
      if (digest_q.size() == 0) begin
        report("unexpected word", word, '0);
        return;
      end
      want = digest_q.pop_front();
      if (word !== want.word) report("word", word, want.word);
      if (index !== want.index) report("index", 32'(index), 32'(want.index));
      if (last !== want.last) report("last", 32'(last), 32'(want.last));
    endtask

    function int pending();
      return digest_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // data_word
  logic [2:0]  s_axis_tuser = '0;   // byte_count
  logic        s_axis_tlast = 1'b0; // last_word
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // digest_word
  logic [2:0]  m_axis_tuser;        // digest_index
  logic        m_axis_tlast;        // digest_last

  digest_scoreboard sb = new();
  bit full_rate = 1'b0;
  int items_sent = 0;

  sha1_hash_engine DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function int pick_gap();
    int r;
    if (full_rate) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // Entered right after a rising edge; returns right after the accepting edge.
  task send_word(word_t data, logic [2:0] count, logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= count;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_request(data, count, last);
    items_sent++;
  endtask

  // Output side: check accepted digest words and throttle tready.
  initial begin
    int  ready_left;
    bit  ready_val;
    int  r;
    ready_left = 0;
    ready_val  = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready)
        sb.check_digest(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      if (ready_left > 0) begin
        ready_left--;
      end else if (full_rate) begin
        ready_val  = 1'b1;
        ready_left = 0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          ready_val  = 1'b1;
          ready_left = $urandom_range(0, 20);
        end else if (r < 93) begin
          ready_val  = 1'b0;
          ready_left = $urandom_range(0, 3);
        end else begin
          ready_val  = 1'b0;
          ready_left = $urandom_range(30, 80);
        end
      end
      m_axis_tready <= ready_val;
    end
  end

  initial begin
    int n;
    int r;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // One-word messages of zero to four bytes, starting with the empty message, with junk in some ignored bytes.
    send_word(32'hFFFF_FFFF, 3'd0, 1'b1);
    send_word(32'h6162_63FF, 3'd3, 1'b1);
    send_word(32'hFFFF_FFFF, 3'd1, 1'b1);
    send_word(32'h0000_0000, 3'd2, 1'b1);
    send_word(32'hFFFF_FFFF, 3'd4, 1'b1);
    // Counts above four are taken as four.
    send_word(32'h1234_5678, 3'd7, 1'b1);
    send_word(32'h0000_0000, 3'd5, 1'b1);
    // Short count on a word that is not last counts as four bytes.
    send_word(32'hFFFF_FFFF, 3'd0, 1'b0);
    send_word(32'hA5A5_A5A5, 3'd6, 1'b1);
    // Last word lands in slot 14, so the length spills into a second block.
    for (int i = 0; i < 14; i++)
      send_word((i % 2) ? 32'hFFFF_FFFF : $urandom, (i == 5) ? 3'd2 : 3'd4, 1'b0);
    send_word($urandom, 3'd3, 1'b1);

    while (items_sent < 225) begin
      full_rate = ($urandom_range(0, 99) < 15);
      r = $urandom_range(0, 99);
      if (r < 60) n = $urandom_range(0, 6);
      else if (r < 90) n = $urandom_range(7, 20);
      else n = $urandom_range(21, 40);
      for (int i = 0; i < n; i++)
        send_word($urandom, ($urandom_range(0, 99) < 85) ? 3'd4 : 3'($urandom_range(0, 7)),
                  1'b0);
      send_word($urandom, 3'($urandom_range(0, 7)), 1'b1);
    end
    full_rate = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
